>>> rtl/trd_pkg.sv
// Package with the types, constants and exponential table of the thermal runaway decay step.
package trd_pkg;

    localparam int EXP_TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);

    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [16:0] EXP_M1_Q16 = 17'd24109;
    localparam logic [16:0] RATE_BASE = 17'd9830;
    localparam logic [16:0] RATE_SLOPE = 17'd55706;
    localparam logic [47:0] HEAT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] GAS_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [63:0] US_PER_S = 64'd1000000;
    localparam logic [63:0] US_PER_MS = 64'd1000;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_ONSET = 3'd1;
    localparam logic [2:0] REG_FULL = 3'd2;
    localparam logic [2:0] REG_TAU = 3'd3;
    localparam logic [2:0] REG_ENERGY = 3'd4;
    localparam logic [2:0] REG_GAS = 3'd5;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic [19:0] step_time_us;
        logic [15:0] temperature;
    } t_in;

    typedef struct packed {
        logic [47:0] heat_power_mw;
        logic [39:0] gas_rate_ugps;
        logic        runaway_active;
    } t_out;

    typedef struct packed {
        logic start;
        logic op;
    } t_alu_req;

    typedef logic [16:0] t_exp_tab [0:EXP_TABLE_DEPTH];

    function automatic t_exp_tab f_exp_tab();
        t_exp_tab    tab;
        logic [63:0] y;
        logic [63:0] mag;
        longint      sum;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            y = (64'(k) << 30) / EXP_TABLE_DEPTH;
            mag = 64'd1 << 30;
            sum = longint'(mag);
            for (int n = 1; n <= 24; n++) begin
                mag = ((mag * y) >> 30) / 64'(n);
                if ((n % 2) == 1) begin
                    sum = sum - longint'(mag);
                end else begin
                    sum = sum + longint'(mag);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = 17'((sum + 8192) >>> 14);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = f_exp_tab();

endpackage

>>> rtl/thermal_runaway_decay_step.sv
// Top level of the thermal runaway decay step.
// Usage: one input channel (i_in_valid, o_in_stall, i_in_data) carries a time step
// and a cell temperature; one output channel (o_out_valid, i_out_stall, o_out_data)
// returns heat power, gas rate and the runaway flag, one result per transfer.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data; the user
// is to write them only while idle, which the block itself does not enforce.
// Every multiply and divide goes one bit per cycle through a single shared
// serial unit: about a dozen operations plus up to a dozen steps of the exp(-1)
// loop. When the model is disabled or not triggered, no operation is run.
// One item is in work at a time; o_in_stall is high from the transfer until the
// result is placed in the output register, so the next item may enter while a
// finished result still waits. A stalled result holds its value.
// Reset loads the register defaults, clears the runaway flag and both stores.
module thermal_runaway_decay_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  trd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output trd_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [39:0]   i_cfg_data
);
    import trd_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PROG = 4'd1;
    localparam logic [3:0] ST_R = 4'd2;
    localparam logic [3:0] ST_RDT = 4'd3;
    localparam logic [3:0] ST_TAU = 4'd4;
    localparam logic [3:0] ST_X = 4'd5;
    localparam logic [3:0] ST_INT = 4'd6;
    localparam logic [3:0] ST_EXP = 4'd7;
    localparam logic [3:0] ST_DE = 4'd8;
    localparam logic [3:0] ST_DM = 4'd9;
    localparam logic [3:0] ST_H1 = 4'd10;
    localparam logic [3:0] ST_H2 = 4'd11;
    localparam logic [3:0] ST_G1 = 4'd12;
    localparam logic [3:0] ST_G2 = 4'd13;
    localparam logic [3:0] ST_FIN = 4'd14;

    logic [3:0]  r_state, n_state;
    logic        r_issued, n_issued;
    logic        r_ovalid, n_ovalid;
    t_out        r_out, n_out;
    logic        r_enable, n_enable;
    logic [15:0] r_onset, n_onset;
    logic [15:0] r_full, n_full;
    logic [19:0] r_tau, n_tau;
    logic        r_trig, n_trig;
    logic [39:0] r_energy, n_energy;
    logic [31:0] r_gas, n_gas;

    logic [19:0] r_dt, n_dt;
    logic [15:0] r_temp, n_temp;
    logic [16:0] r_prog, n_prog;
    logic [16:0] r_rate, n_rate;
    logic [36:0] r_rdt, n_rdt;
    logic [29:0] r_taum, n_taum;
    logic [36:0] r_x, n_x;
    logic [16:0] r_e, n_e;
    logic [20:0] r_cnt, n_cnt;
    logic [16:0] r_frac, n_frac;
    logic [39:0] r_de, n_de;
    logic [31:0] r_dm, n_dm;
    logic [59:0] r_prod, n_prod;
    logic [47:0] r_heat, n_heat;
    logic [39:0] r_gasr, n_gasr;

    t_alu_req    alu_req;
    logic [63:0] alu_a, alu_b, alu_res;
    logic        alu_done;

    logic [15:0] span, num;
    logic [19:0] tau1;
    logic [31:0] pos;
    logic [15:0] idx_raw;
    logic [IDX_W-1:0] idx;
    logic [16:0] tab_a, tab_b;
    logic        go;

    trd_serial_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    always_comb begin
        span = (r_full > r_onset) ? (r_full - r_onset) : 16'd1;
        num = (r_temp > r_onset) ? (r_temp - r_onset) : 16'd0;
        tau1 = (r_tau == 20'd0) ? 20'd1 : r_tau;
        pos = 32'(r_x[15:0]) * 32'(EXP_TABLE_DEPTH);
        idx_raw = pos[31:16];
        idx = (32'(idx_raw) >= 32'(EXP_TABLE_DEPTH)) ? IDX_W'(EXP_TABLE_DEPTH - 1)
                                                     : IDX_W'(idx_raw);
        tab_a = EXP_TAB[idx];
        tab_b = EXP_TAB[idx + IDX_W'(1)];
        go = r_enable && (i_in_data.step_time_us != 20'd0)
             && !((r_energy <= 40'd1000) && (r_gas <= 32'd1));
    end

    always_comb begin
        n_state = r_state;
        n_issued = r_issued;
        n_ovalid = r_ovalid;
        n_out = r_out;
        n_enable = r_enable;
        n_onset = r_onset;
        n_full = r_full;
        n_tau = r_tau;
        n_trig = r_trig;
        n_energy = r_energy;
        n_gas = r_gas;
        n_dt = r_dt;
        n_temp = r_temp;
        n_prog = r_prog;
        n_rate = r_rate;
        n_rdt = r_rdt;
        n_taum = r_taum;
        n_x = r_x;
        n_e = r_e;
        n_cnt = r_cnt;
        n_frac = r_frac;
        n_de = r_de;
        n_dm = r_dm;
        n_prod = r_prod;
        n_heat = r_heat;
        n_gasr = r_gasr;
        alu_req = '0;
        alu_a = 64'd0;
        alu_b = 64'd0;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_dt = i_in_data.step_time_us;
                    n_temp = i_in_data.temperature;
                    n_heat = 48'd0;
                    n_gasr = 40'd0;
                    n_state = ST_FIN;
                    if (go) begin
                        if (r_trig || (i_in_data.temperature >= r_onset)) begin
                            n_trig = 1'b1;
                            n_state = ST_PROG;
                        end
                    end
                end
            end
            ST_PROG: begin
                alu_req.op = OP_DIV;
                alu_a = {32'd0, num, 16'd0};
                alu_b = {48'd0, span};
                if (num == 16'd0) begin
                    n_prog = 17'd0;
                    n_state = ST_R;
                end else if (num >= span) begin
                    n_prog = Q16_ONE;
                    n_state = ST_R;
                end else if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_prog = alu_res[16:0];
                    n_state = ST_R;
                end
            end
            ST_R: begin
                alu_req.op = OP_MUL;
                alu_a = {47'd0, RATE_SLOPE};
                alu_b = {47'd0, r_prog};
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_rate = RATE_BASE + alu_res[32:16];
                    n_state = ST_RDT;
                end
            end
            ST_RDT: begin
                alu_req.op = OP_MUL;
                alu_a = {47'd0, r_rate};
                alu_b = {44'd0, r_dt};
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_rdt = alu_res[36:0];
                    n_state = ST_TAU;
                end
            end
            ST_TAU: begin
                alu_req.op = OP_MUL;
                alu_a = {44'd0, tau1};
                alu_b = US_PER_MS;
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_taum = alu_res[29:0];
                    n_state = ST_X;
                end
            end
            ST_X: begin
                alu_req.op = OP_DIV;
                alu_a = {27'd0, r_rdt};
                alu_b = {34'd0, r_taum};
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_x = alu_res[36:0];
                    n_cnt = 21'd0;
                    n_state = ST_INT;
                end
            end
            ST_INT: begin
                alu_req.op = OP_MUL;
                alu_a = {47'd0, tab_a - tab_b};
                alu_b = {48'd0, pos[15:0]};
                if (!(tab_b < tab_a)) begin
                    n_e = tab_a;
                    n_state = ST_EXP;
                end else if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_e = tab_a - alu_res[32:16];
                    n_state = ST_EXP;
                end
            end
            ST_EXP: begin
                alu_req.op = OP_MUL;
                alu_a = {47'd0, r_e};
                alu_b = {47'd0, EXP_M1_Q16};
                if ((r_cnt == r_x[36:16]) || (r_e == 17'd0)) begin
                    n_frac = Q16_ONE - r_e;
                    n_state = ST_DE;
                end else if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_e = alu_res[32:16];
                    n_cnt = r_cnt + 21'd1;
                end
            end
            ST_DE: begin
                alu_req.op = OP_MUL;
                alu_a = {24'd0, r_energy};
                alu_b = {47'd0, r_frac};
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_de = alu_res[55:16];
                    n_energy = r_energy - alu_res[55:16];
                    n_state = ST_DM;
                end
            end
            ST_DM: begin
                alu_req.op = OP_MUL;
                alu_a = {32'd0, r_gas};
                alu_b = {47'd0, r_frac};
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_dm = alu_res[47:16];
                    n_gas = r_gas - alu_res[47:16];
                    n_state = ST_H1;
                end
            end
            ST_H1: begin
                alu_req.op = OP_MUL;
                alu_a = {24'd0, r_de};
                alu_b = US_PER_S;
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_prod = alu_res[59:0];
                    n_state = ST_H2;
                end
            end
            ST_H2: begin
                alu_req.op = OP_DIV;
                alu_a = {4'd0, r_prod};
                alu_b = {44'd0, r_dt};
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_heat = (alu_res > {16'd0, HEAT_MAX}) ? HEAT_MAX : alu_res[47:0];
                    n_state = ST_G1;
                end
            end
            ST_G1: begin
                alu_req.op = OP_MUL;
                alu_a = {32'd0, r_dm};
                alu_b = US_PER_S;
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_prod = alu_res[59:0];
                    n_state = ST_G2;
                end
            end
            ST_G2: begin
                alu_req.op = OP_DIV;
                alu_a = {4'd0, r_prod};
                alu_b = {44'd0, r_dt};
                if (!r_issued) begin
                    alu_req.start = 1'b1;
                    n_issued = 1'b1;
                end else if (alu_done) begin
                    n_issued = 1'b0;
                    n_gasr = (alu_res > {24'd0, GAS_MAX}) ? GAS_MAX : alu_res[39:0];
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out.heat_power_mw = r_heat;
                    n_out.gas_rate_ugps = r_gasr;
                    n_out.runaway_active = r_trig;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENABLE: n_enable = i_cfg_data[0];
                REG_ONSET:  n_onset = i_cfg_data[15:0];
                REG_FULL:   n_full = i_cfg_data[15:0];
                REG_TAU:    n_tau = i_cfg_data[19:0];
                REG_ENERGY: begin
                    n_energy = i_cfg_data;
                    n_trig = 1'b0;
                end
                REG_GAS: begin
                    n_gas = i_cfg_data[31:0];
                    n_trig = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_enable <= 1'b0;
            r_onset <= 16'd6768;
            r_full <= 16'd8368;
            r_tau <= 20'd10000;
            r_trig <= 1'b0;
            r_energy <= 40'd0;
            r_gas <= 32'd0;
        end else begin
            r_state <= n_state;
            r_issued <= n_issued;
            r_ovalid <= n_ovalid;
            r_enable <= n_enable;
            r_onset <= n_onset;
            r_full <= n_full;
            r_tau <= n_tau;
            r_trig <= n_trig;
            r_energy <= n_energy;
            r_gas <= n_gas;
        end
        r_out <= n_out;
        r_dt <= n_dt;
        r_temp <= n_temp;
        r_prog <= n_prog;
        r_rate <= n_rate;
        r_rdt <= n_rdt;
        r_taum <= n_taum;
        r_x <= n_x;
        r_e <= n_e;
        r_cnt <= n_cnt;
        r_frac <= n_frac;
        r_de <= n_de;
        r_dm <= n_dm;
        r_prod <= n_prod;
        r_heat <= n_heat;
        r_gasr <= n_gasr;
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data = r_out;

`ifndef NO_ASSERTIONS
    a_heat_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.heat_power_mw != 48'd0) |-> o_out_data.runaway_active)
        else $error("heat reported without runaway flag");
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DE) |-> (r_frac <= Q16_ONE))
        else $error("decay fraction out of range");
    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R) |-> (r_prog <= Q16_ONE))
        else $error("progress out of range");
`endif

endmodule

>>> rtl/trd_serial_alu.sv
// Bit-serial shift-add multiplier and restoring divider shared by all arithmetic steps.
module trd_serial_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trd_pkg::t_alu_req i_req,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    output logic              o_done,
    output logic [63:0]       o_result
);
    import trd_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_op, n_op;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_acc, n_acc;
    logic [64:0] r_rem, n_rem;
    logic [64:0] rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op = r_op;
        n_cnt = r_cnt;
        n_a = r_a;
        n_b = r_b;
        n_acc = r_acc;
        n_rem = r_rem;
        rem_sh = {r_rem[63:0], r_a[63]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op = i_req.op;
            n_cnt = 7'd0;
            n_a = i_a;
            n_b = i_b;
            n_acc = 64'd0;
            n_rem = 65'd0;
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                if (r_b == 64'd0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    if (r_b[0]) begin
                        n_acc = r_acc + r_a;
                    end
                    n_a = {r_a[62:0], 1'b0};
                    n_b = {1'b0, r_b[63:1]};
                end
            end else begin
                if (r_cnt == 7'd64) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    if (rem_sh >= {1'b0, r_b}) begin
                        n_rem = rem_sh - {1'b0, r_b};
                        n_a = {r_a[62:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_a = {r_a[62:0], 1'b0};
                    end
                    n_cnt = r_cnt + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op <= n_op;
        r_cnt <= n_cnt;
        r_a <= n_a;
        r_b <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_result = (r_op == OP_DIV) ? r_a : r_acc;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a running operation");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_op == OP_DIV) |-> r_cnt <= 7'd64) else $error("divider overran");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_op == OP_DIV && r_b != 64'd0) |-> r_rem < {1'b0, r_b})
        else $error("remainder not below divisor");
`endif

endmodule
